>>> rtl/tpc_pkg.sv
// Package with the shared widths, fixed-point constants and sample offsets of the coverage test.
package tpc_pkg;

  // Fixed-point format of the vertices and of the pixel grid.
  localparam int SUBPIXEL_BITS    = 4;
  localparam int PIXEL_COORD_BITS = 12;

  // Payload field widths.
  localparam int VERT_W      = 16;
  localparam int PIX_FIELD_W = 12;
  localparam int MASK_W      = 4;
  localparam int COUNT_W     = 3;
  localparam int EDGE_OUT_W  = 35;

  // Only as many pixel bits as both the field and the coordinate range allow are used.
  localparam int PIX_USE_W = (PIXEL_COORD_BITS < PIX_FIELD_W) ? PIXEL_COORD_BITS : PIX_FIELD_W;
  localparam int POS_W     = PIX_USE_W + SUBPIXEL_BITS;

  // Corner-relative position (pixel corner minus vertex), signed.
  localparam int REL_W  = ((POS_W > VERT_W) ? POS_W : VERT_W) + 2;
  // Edge direction (target minus origin vertex), signed.
  localparam int DIR_W  = VERT_W + 1;
  // One cross-product term, the corner edge value and a sample edge value.
  localparam int PROD_W = REL_W + DIR_W;
  localparam int EDGE_W = PROD_W + 1;
  localparam int SAMP_W = EDGE_W + 1;

  // Sample offsets of a quarter and three quarters of a pixel, in subpixel units.
  localparam int Q1 = 1 << (SUBPIXEL_BITS - 2);
  localparam int Q3 = 3 * Q1;

  // Number of edges and samples per pixel.
  localparam int EDGES   = 3;
  localparam int SAMPLES = 4;

endpackage

>>> rtl/tpc_if.sv
// Valid/ready channel interfaces for the pixel items in and the coverage items out.
interface tpc_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [tpc_pkg::VERT_W-1:0] vertex_a_x;
  logic signed [tpc_pkg::VERT_W-1:0] vertex_a_y;
  logic signed [tpc_pkg::VERT_W-1:0] vertex_b_x;
  logic signed [tpc_pkg::VERT_W-1:0] vertex_b_y;
  logic signed [tpc_pkg::VERT_W-1:0] vertex_c_x;
  logic signed [tpc_pkg::VERT_W-1:0] vertex_c_y;
  logic [tpc_pkg::PIX_FIELD_W-1:0]   pixel_x;
  logic [tpc_pkg::PIX_FIELD_W-1:0]   pixel_y;

  modport source (
    output valid, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
           vertex_c_x, vertex_c_y, pixel_x, pixel_y,
    input  ready
  );
  modport sink (
    input  valid, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
           vertex_c_x, vertex_c_y, pixel_x, pixel_y,
    output ready
  );
endinterface

interface tpc_out_if;
  logic                                  valid;
  logic                                  ready;
  logic [tpc_pkg::MASK_W-1:0]            sample_mask;
  logic [tpc_pkg::COUNT_W-1:0]           covered_count;
  logic signed [tpc_pkg::EDGE_OUT_W-1:0] edge_value_a;
  logic signed [tpc_pkg::EDGE_OUT_W-1:0] edge_value_b;
  logic signed [tpc_pkg::EDGE_OUT_W-1:0] edge_value_c;

  modport source (
    output valid, sample_mask, covered_count, edge_value_a, edge_value_b, edge_value_c,
    input  ready
  );
  modport sink (
    input  valid, sample_mask, covered_count, edge_value_a, edge_value_b, edge_value_c,
    output ready
  );
endinterface

>>> rtl/triangle_pixel_coverage_test_top.sv
// Top level of the four-sample triangle coverage test: a four-stage edge-function pipeline.
//
//   port     dir  carries
//   pix_in   in   three vertices and a pixel coordinate per item
//   cov_out  out  sample mask, covered count and three corner edge values per item
//
// One item enters per cycle while pix_in.ready is high. An item passes four register stages
// (differences, multipliers, corner edge value, sample tests) in that order and leaves from
// the output register. The two multipliers per edge in stage two set the depth of the
// longest stage.
// Reset clears only the stage valid bits. A stall at the output holds the full stages
// and lets bubbles close up, so pix_in.ready stays high while any stage is empty.
module triangle_pixel_coverage_test_top (
  input logic          clk,
  input logic          rst,
  tpc_in_if.sink       pix_in,
  tpc_out_if.source    cov_out
);

  // Stage valid bits and advance enables.
  logic v1, v2, v3, v4;
  logic adv1, adv2, adv3, adv4;

  assign adv4 = !v4 || cov_out.ready;
  assign adv3 = !v3 || adv4;
  assign adv2 = !v2 || adv3;
  assign adv1 = !v1 || adv2;
  assign pix_in.ready = adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (adv1) v1 <= pix_in.valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
      if (adv4) v4 <= v3;
    end
  end

  // Pixel corner in subpixel units and the vertices, widened to the difference width.
  logic signed [tpc_pkg::REL_W-1:0] corner_x, corner_y;
  logic signed [tpc_pkg::REL_W-1:0] org_x [tpc_pkg::EDGES];
  logic signed [tpc_pkg::REL_W-1:0] org_y [tpc_pkg::EDGES];
  logic signed [tpc_pkg::DIR_W-1:0] dir_x [tpc_pkg::EDGES];
  logic signed [tpc_pkg::DIR_W-1:0] dir_y [tpc_pkg::EDGES];
  logic                             tl    [tpc_pkg::EDGES];

  assign corner_x = tpc_pkg::REL_W'({1'b0, pix_in.pixel_x[tpc_pkg::PIX_USE_W-1:0],
                                     {tpc_pkg::SUBPIXEL_BITS{1'b0}}});
  assign corner_y = tpc_pkg::REL_W'({1'b0, pix_in.pixel_y[tpc_pkg::PIX_USE_W-1:0],
                                     {tpc_pkg::SUBPIXEL_BITS{1'b0}}});

  // Edge A runs from b to c, edge B from c to a, edge C from a to b.
  always_comb begin
    org_x[0] = tpc_pkg::REL_W'(pix_in.vertex_b_x);
    org_y[0] = tpc_pkg::REL_W'(pix_in.vertex_b_y);
    org_x[1] = tpc_pkg::REL_W'(pix_in.vertex_c_x);
    org_y[1] = tpc_pkg::REL_W'(pix_in.vertex_c_y);
    org_x[2] = tpc_pkg::REL_W'(pix_in.vertex_a_x);
    org_y[2] = tpc_pkg::REL_W'(pix_in.vertex_a_y);
    dir_x[0] = tpc_pkg::DIR_W'(pix_in.vertex_c_x) - tpc_pkg::DIR_W'(pix_in.vertex_b_x);
    dir_y[0] = tpc_pkg::DIR_W'(pix_in.vertex_c_y) - tpc_pkg::DIR_W'(pix_in.vertex_b_y);
    dir_x[1] = tpc_pkg::DIR_W'(pix_in.vertex_a_x) - tpc_pkg::DIR_W'(pix_in.vertex_c_x);
    dir_y[1] = tpc_pkg::DIR_W'(pix_in.vertex_a_y) - tpc_pkg::DIR_W'(pix_in.vertex_c_y);
    dir_x[2] = tpc_pkg::DIR_W'(pix_in.vertex_b_x) - tpc_pkg::DIR_W'(pix_in.vertex_a_x);
    dir_y[2] = tpc_pkg::DIR_W'(pix_in.vertex_b_y) - tpc_pkg::DIR_W'(pix_in.vertex_a_y);
  end

  // The top-left test looks at the reversed direction, so a top edge here runs toward
  // negative x with no y change, and a left edge runs toward positive y.
  always_comb begin
    for (int e = 0; e < tpc_pkg::EDGES; e++) begin
      tl[e] = (dir_y[e] == '0 && dir_x[e] < 0) || dir_y[e] > 0;
    end
  end

  // Stage 1: corner-relative positions, edge directions and top-left flags.
  logic signed [tpc_pkg::REL_W-1:0] s1_rx [tpc_pkg::EDGES];
  logic signed [tpc_pkg::REL_W-1:0] s1_ry [tpc_pkg::EDGES];
  logic signed [tpc_pkg::DIR_W-1:0] s1_dx [tpc_pkg::EDGES];
  logic signed [tpc_pkg::DIR_W-1:0] s1_dy [tpc_pkg::EDGES];
  logic                             s1_tl [tpc_pkg::EDGES];

  always_ff @(posedge clk) begin
    if (adv1 && pix_in.valid) begin
      for (int e = 0; e < tpc_pkg::EDGES; e++) begin
        s1_rx[e] <= corner_x - org_x[e];
        s1_ry[e] <= corner_y - org_y[e];
        s1_dx[e] <= dir_x[e];
        s1_dy[e] <= dir_y[e];
        s1_tl[e] <= tl[e];
      end
    end
  end

  // Stage 2: the two cross-product terms of each edge.
  logic signed [tpc_pkg::PROD_W-1:0] s2_m1 [tpc_pkg::EDGES];
  logic signed [tpc_pkg::PROD_W-1:0] s2_m2 [tpc_pkg::EDGES];
  logic signed [tpc_pkg::DIR_W-1:0]  s2_dx [tpc_pkg::EDGES];
  logic signed [tpc_pkg::DIR_W-1:0]  s2_dy [tpc_pkg::EDGES];
  logic                              s2_tl [tpc_pkg::EDGES];

  always_ff @(posedge clk) begin
    if (adv2 && v1) begin
      for (int e = 0; e < tpc_pkg::EDGES; e++) begin
        s2_m1[e] <= tpc_pkg::PROD_W'(s1_rx[e]) * tpc_pkg::PROD_W'(s1_dy[e]);
        s2_m2[e] <= tpc_pkg::PROD_W'(s1_ry[e]) * tpc_pkg::PROD_W'(s1_dx[e]);
        s2_dx[e] <= s1_dx[e];
        s2_dy[e] <= s1_dy[e];
        s2_tl[e] <= s1_tl[e];
      end
    end
  end

  // Stage 3: exact edge value at the pixel corner.
  logic signed [tpc_pkg::EDGE_W-1:0] s3_e0 [tpc_pkg::EDGES];
  logic signed [tpc_pkg::DIR_W-1:0]  s3_dx [tpc_pkg::EDGES];
  logic signed [tpc_pkg::DIR_W-1:0]  s3_dy [tpc_pkg::EDGES];
  logic                              s3_tl [tpc_pkg::EDGES];

  always_ff @(posedge clk) begin
    if (adv3 && v2) begin
      for (int e = 0; e < tpc_pkg::EDGES; e++) begin
        s3_e0[e] <= tpc_pkg::EDGE_W'(s2_m1[e]) - tpc_pkg::EDGE_W'(s2_m2[e]);
        s3_dx[e] <= s2_dx[e];
        s3_dy[e] <= s2_dy[e];
        s3_tl[e] <= s2_tl[e];
      end
    end
  end

  // Sample tests: the edge function is linear, so each sample value is the corner value
  // plus the offset times the edge direction.
  localparam logic signed [tpc_pkg::SAMP_W-1:0] OFF1 = tpc_pkg::SAMP_W'(tpc_pkg::Q1);
  localparam logic signed [tpc_pkg::SAMP_W-1:0] OFF3 = tpc_pkg::SAMP_W'(tpc_pkg::Q3);

  logic signed [tpc_pkg::SAMP_W-1:0] dy_q1 [tpc_pkg::EDGES];
  logic signed [tpc_pkg::SAMP_W-1:0] dy_q3 [tpc_pkg::EDGES];
  logic signed [tpc_pkg::SAMP_W-1:0] dx_q1 [tpc_pkg::EDGES];
  logic signed [tpc_pkg::SAMP_W-1:0] dx_q3 [tpc_pkg::EDGES];
  logic signed [tpc_pkg::SAMP_W-1:0] samp_val;
  logic [tpc_pkg::MASK_W-1:0]        mask;
  logic [tpc_pkg::COUNT_W-1:0]       count;
  logic                              hit;

  always_comb begin
    for (int e = 0; e < tpc_pkg::EDGES; e++) begin
      dy_q1[e] = tpc_pkg::SAMP_W'(s3_dy[e]) * OFF1;
      dy_q3[e] = tpc_pkg::SAMP_W'(s3_dy[e]) * OFF3;
      dx_q1[e] = tpc_pkg::SAMP_W'(s3_dx[e]) * OFF1;
      dx_q3[e] = tpc_pkg::SAMP_W'(s3_dx[e]) * OFF3;
    end
  end

  always_comb begin
    mask     = '0;
    samp_val = '0;
    for (int k = 0; k < tpc_pkg::SAMPLES; k++) begin
      hit = 1'b1;
      for (int e = 0; e < tpc_pkg::EDGES; e++) begin
        samp_val = tpc_pkg::SAMP_W'(s3_e0[e])
                 + (k[0] ? dy_q3[e] : dy_q1[e])
                 - (k[1] ? dx_q3[e] : dx_q1[e]);
        if (!(samp_val < 0 || (samp_val == '0 && s3_tl[e]))) begin
          hit = 1'b0;
        end
      end
      mask[k] = hit;
    end
  end

  assign count = tpc_pkg::COUNT_W'(mask[0]) + tpc_pkg::COUNT_W'(mask[1])
               + tpc_pkg::COUNT_W'(mask[2]) + tpc_pkg::COUNT_W'(mask[3]);

  // Stage 4: output register.
  logic [tpc_pkg::MASK_W-1:0]            out_mask;
  logic [tpc_pkg::COUNT_W-1:0]           out_count;
  logic signed [tpc_pkg::EDGE_OUT_W-1:0] out_edge [tpc_pkg::EDGES];

  always_ff @(posedge clk) begin
    if (adv4 && v3) begin
      out_mask  <= mask;
      out_count <= count;
      for (int e = 0; e < tpc_pkg::EDGES; e++) begin
        out_edge[e] <= signed'(s3_e0[e][tpc_pkg::EDGE_OUT_W-1:0]);
      end
    end
  end

  assign cov_out.valid         = v4;
  assign cov_out.sample_mask   = out_mask;
  assign cov_out.covered_count = out_count;
  assign cov_out.edge_value_a  = out_edge[0];
  assign cov_out.edge_value_b  = out_edge[1];
  assign cov_out.edge_value_c  = out_edge[2];

  // The count always agrees with the mask it was built from.
  assert property (@(posedge clk) disable iff (rst)
    cov_out.valid |-> cov_out.covered_count == tpc_pkg::COUNT_W'($countones(cov_out.sample_mask)))
    else $error("covered count does not match sample mask");

  // Input back-pressure only when every stage holds an item.
  assert property (@(posedge clk) disable iff (rst)
    !pix_in.ready |-> (v1 && v2 && v3 && v4 && !cov_out.ready))
    else $error("input stalled while the pipeline has a bubble");

  // A held output item is not overwritten by the stage behind it.
  assert property (@(posedge clk) disable iff (rst)
    (v4 && !cov_out.ready) |=> (v4 && $stable(out_mask) && $stable(out_count)))
    else $error("stalled output item changed");

  // Reset empties the pipeline.
  assert property (@(posedge clk)
    rst |=> (!v1 && !v2 && !v3 && !cov_out.valid))
    else $error("pipeline not empty after reset");

endmodule
